// ===== rtl/core/region_overshoot_statistics_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the region overshoot statistics block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef REGION_OVERSHOOT_STATISTICS_ASSERT_SVH
`define REGION_OVERSHOOT_STATISTICS_ASSERT_SVH

// The condition holds at every clock edge out of reset.
`define ROS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ROS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ROS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ros_pkg.sv =====
// ---------------------------------------------------------------------------
// ros_pkg
// Types, widths and register codes shared by the overshoot statistics block.
// ---------------------------------------------------------------------------
package ros_pkg;

  localparam int unsigned COORD_W    = 24;
  localparam int unsigned DIFF_W     = 25;
  localparam int unsigned DIST_W     = 25;
  localparam int unsigned RAD_W      = 23;
  localparam int unsigned SQ_W       = 50;
  localparam int unsigned REM_W      = DIST_W + 2;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned SUM_W      = 35;
  localparam int unsigned SUMSQ_W    = 60;
  localparam int unsigned MAX_AGENTS = 1024;

  localparam int unsigned ISQ_STEPS  = SQ_W / 2;
  localparam int unsigned ISQ_CW     = 5;
  localparam int unsigned DIV_STEPS  = SUMSQ_W;
  localparam int unsigned DIV_CW     = 6;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  localparam int unsigned APB_AW     = 4;
  localparam int unsigned APB_DW     = 32;

  localparam logic SHAPE_SPHERE = 1'b0;
  localparam logic SHAPE_CUBE   = 1'b1;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS   = 2'd2,
    REG_SHAPE    = 2'd3
  } ros_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      final_agent;
  } ros_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] mean_dist;
    logic [DIST_W-1:0] stdev_dist;
    logic [DIST_W-1:0] min_dist;
    logic [DIST_W-1:0] max_dist;
    logic [CNT_W-1:0]  outside_count;
  } ros_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [RAD_W-1:0]          radius;
    logic                      region_shape;
  } ros_cfg_t;

  typedef struct packed {
    logic [DIST_W-1:0] excess;
    logic              last;
  } ros_q_t;

endpackage

// ===== rtl/core/ros_isqrt.sv =====
// ---------------------------------------------------------------------------
// ros_isqrt
// Iterative floor square root, one result bit per cycle.
// ---------------------------------------------------------------------------
module ros_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ros_pkg::SQ_W-1:0]    x,
  output logic                        done,
  output logic [ros_pkg::DIST_W-1:0]  root
);

  logic [ros_pkg::SQ_W-1:0]   x_r;
  logic [ros_pkg::REM_W-1:0]  rem_r;
  logic [ros_pkg::DIST_W-1:0] root_r;
  logic [ros_pkg::ISQ_CW-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [ros_pkg::REM_W+1:0]  rem_sh;
  logic [ros_pkg::REM_W+1:0]  trial;
  logic                       ge;
  logic [ros_pkg::REM_W+1:0]  rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, x_r[ros_pkg::SQ_W-1 -: 2]};
    trial   = {2'b00, root_r, 2'b01};
    ge      = (rem_sh >= trial);
    rem_nxt = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      if (cnt_r == ros_pkg::ISQ_CW'(ros_pkg::ISQ_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= x;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[ros_pkg::SQ_W-3:0], 2'b00};
      rem_r  <= rem_nxt[ros_pkg::REM_W-1:0];
      root_r <= {root_r[ros_pkg::DIST_W-2:0], ge};
      cnt_r  <= cnt_r + 1'b1;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/core/ros_div.sv =====
// ---------------------------------------------------------------------------
// ros_div
// Iterative restoring divider by an agent count, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ros_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ros_pkg::SUMSQ_W-1:0]  dividend,
  input  logic [ros_pkg::CNT_W-1:0]    divisor,
  output logic                         done,
  output logic [ros_pkg::SUMSQ_W-1:0]  quotient
);

  logic [ros_pkg::SUMSQ_W-1:0] q_r;
  logic [ros_pkg::CNT_W-1:0]   rem_r;
  logic [ros_pkg::CNT_W-1:0]   div_r;
  logic [ros_pkg::DIV_CW-1:0]  cnt_r;
  logic                        busy_r;
  logic                        done_r;

  logic [ros_pkg::CNT_W:0]     rem_sh;
  logic                        ge;
  logic [ros_pkg::CNT_W:0]     rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, q_r[ros_pkg::SUMSQ_W-1]};
    ge      = (rem_sh >= {1'b0, div_r});
    rem_nxt = ge ? (rem_sh - {1'b0, div_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      if (cnt_r == ros_pkg::DIV_CW'(ros_pkg::DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[ros_pkg::SUMSQ_W-2:0], ge};
      rem_r <= rem_nxt[ros_pkg::CNT_W-1:0];
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== rtl/core/ros_fifo.sv =====
// ---------------------------------------------------------------------------
// ros_fifo
// Short queue of outside distances between the front and the back.
// ---------------------------------------------------------------------------
`include "region_overshoot_statistics_assert.svh"

module ros_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ros_pkg::ros_q_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output ros_pkg::ros_q_t head
);

  ros_pkg::ros_q_t            mem_r [ros_pkg::FIFO_DEPTH];
  logic [ros_pkg::FIFO_AW-1:0] wr_ptr_r;
  logic [ros_pkg::FIFO_AW-1:0] rd_ptr_r;
  logic [ros_pkg::FIFO_AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign full      = (cnt_r == (ros_pkg::FIFO_AW+1)'(ros_pkg::FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  `ROS_ASSERT_IMPL(a_no_overflow, push && !pop, !full, "queue written while full")
  `ROS_ASSERT_IMPL(a_no_underflow, pop, not_empty, "queue read while empty")

endmodule

// ===== rtl/core/ros_front.sv =====
// ---------------------------------------------------------------------------
// ros_front
// Takes positions and works out each agent's distance outside the region.
// ---------------------------------------------------------------------------
module ros_front (
  input  logic              clk,
  input  logic              rst_n,
  input  ros_pkg::ros_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  ros_pkg::ros_in_t  in_data,
  output logic              q_push,
  output ros_pkg::ros_q_t   q_data,
  input  logic              q_full
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_SQ   = 5'b00010,
    F_ROOT = 5'b00100,
    F_WAIT = 5'b01000,
    F_PUSH = 5'b10000
  } front_state_t;

  front_state_t state_r;
  front_state_t state_nxt;

  logic signed [ros_pkg::DIFF_W-1:0] d [3];
  logic [ros_pkg::DIST_W-1:0]        m [3];
  logic [ros_pkg::DIST_W-1:0]        a_nxt [3];
  logic [ros_pkg::DIST_W-1:0]        a_r [3];
  logic [ros_pkg::SQ_W-1:0]          sq_r [3];
  logic [ros_pkg::DIST_W-1:0]        rad_ext;
  logic [ros_pkg::SQ_W-1:0]          sum_sq;
  logic                              last_r;
  logic [ros_pkg::DIST_W-1:0]        dist_r;
  logic                              isq_start;
  logic                              isq_done;
  logic [ros_pkg::DIST_W-1:0]        isq_root;

  // Axis offsets from the centre; the centre lies at z equal to zero.
  always_comb begin
    rad_ext = {{(ros_pkg::DIST_W-ros_pkg::RAD_W){1'b0}}, cfg.radius};
    d[0] = {cfg.center_x[ros_pkg::COORD_W-1], cfg.center_x}
         - {in_data.pos_x[ros_pkg::COORD_W-1], in_data.pos_x};
    d[1] = {cfg.center_y[ros_pkg::COORD_W-1], cfg.center_y}
         - {in_data.pos_y[ros_pkg::COORD_W-1], in_data.pos_y};
    d[2] = '0 - {in_data.pos_z[ros_pkg::COORD_W-1], in_data.pos_z};
    for (int i = 0; i < 3; i++) begin
      m[i] = d[i][ros_pkg::DIFF_W-1] ? ros_pkg::DIST_W'(-d[i]) : ros_pkg::DIST_W'(d[i]);
      if (cfg.region_shape == ros_pkg::SHAPE_CUBE) begin
        a_nxt[i] = (m[i] >= rad_ext) ? (m[i] - rad_ext) : '0;
      end else begin
        a_nxt[i] = m[i];
      end
    end
    sum_sq = sq_r[0] + sq_r[1] + sq_r[2];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          state_nxt = F_SQ;
        end
      end
      F_SQ:   state_nxt = F_ROOT;
      F_ROOT: state_nxt = F_WAIT;
      F_WAIT: begin
        if (isq_done) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_valid) begin
      a_r    <= a_nxt;
      last_r <= in_data.final_agent;
    end
    if (state_r == F_SQ) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= a_r[i] * a_r[i];
      end
    end
    if (state_r == F_WAIT && isq_done) begin
      if (cfg.region_shape == ros_pkg::SHAPE_CUBE) begin
        dist_r <= isq_root;
      end else begin
        dist_r <= (isq_root > rad_ext) ? (isq_root - rad_ext) : '0;
      end
    end
  end

  assign isq_start = (state_r == F_ROOT);

  ros_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (isq_start),
    .x     (sum_sq),
    .done  (isq_done),
    .root  (isq_root)
  );

  assign in_ready      = (state_r == F_IDLE);
  assign q_push        = (state_r == F_PUSH) && !q_full;
  assign q_data.excess = dist_r;
  assign q_data.last   = last_r;

endmodule

// ===== rtl/core/ros_back.sv =====
// ---------------------------------------------------------------------------
// ros_back
// Accumulates outside distances and finishes the statistics of each frame.
// ---------------------------------------------------------------------------
`include "region_overshoot_statistics_assert.svh"

module ros_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  ros_pkg::ros_q_t   q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output ros_pkg::ros_out_t out_data
);

  typedef enum logic [5:0] {
    B_ACC   = 6'b000001,
    B_START = 6'b000010,
    B_DIV   = 6'b000100,
    B_SQM   = 6'b001000,
    B_ROOT  = 6'b010000,
    B_WAIT  = 6'b100000
  } back_state_t;

  back_state_t state_r;
  back_state_t state_nxt;

  logic [ros_pkg::CNT_W-1:0]   count_r;
  logic [ros_pkg::SUM_W-1:0]   sum_r;
  logic [ros_pkg::SUMSQ_W-1:0] sumsq_r;
  logic [ros_pkg::DIST_W-1:0]  min_r;
  logic [ros_pkg::DIST_W-1:0]  max_r;

  logic [ros_pkg::CNT_W-1:0]   count_nxt;
  logic [ros_pkg::SUM_W-1:0]   sum_nxt;
  logic [ros_pkg::SUMSQ_W-1:0] sumsq_nxt;
  logic [ros_pkg::DIST_W-1:0]  min_nxt;
  logic [ros_pkg::DIST_W-1:0]  max_nxt;

  logic [ros_pkg::CNT_W-1:0]   snap_cnt_r;
  logic [ros_pkg::SUM_W-1:0]   snap_sum_r;
  logic [ros_pkg::SUMSQ_W-1:0] snap_sumsq_r;
  logic [ros_pkg::DIST_W-1:0]  snap_min_r;
  logic [ros_pkg::DIST_W-1:0]  snap_max_r;

  logic [ros_pkg::DIST_W-1:0]  mean_r;
  logic [ros_pkg::SQ_W-1:0]    msq_r;
  logic [ros_pkg::SQ_W-1:0]    m2_r;
  logic [ros_pkg::SQ_W-1:0]    var_sq;
  logic [ros_pkg::SQ_W-1:0]    dd;
  logic                        hit;

  logic                        out_valid_r;
  ros_pkg::ros_out_t           out_data_r;

  logic                        div_start;
  logic                        div_done;
  logic                        div_done_sq;
  logic [ros_pkg::SUMSQ_W-1:0] q_mean;
  logic [ros_pkg::SUMSQ_W-1:0] q_msq;
  logic                        isq_start;
  logic                        isq_done;
  logic [ros_pkg::DIST_W-1:0]  isq_root;

  assign q_pop = (state_r == B_ACC) && q_valid && (!q_head.last || !out_valid_r);

  // Running update; counting stops once the frame holds the agent limit.
  always_comb begin
    hit = (q_head.excess != '0) && (count_r < ros_pkg::CNT_W'(ros_pkg::MAX_AGENTS));
    dd  = q_head.excess * q_head.excess;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    sumsq_nxt = sumsq_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    if (hit) begin
      count_nxt = count_r + 1'b1;
      sum_nxt   = sum_r + ros_pkg::SUM_W'(q_head.excess);
      sumsq_nxt = sumsq_r + ros_pkg::SUMSQ_W'(dd);
      min_nxt   = (q_head.excess < min_r) ? q_head.excess : min_r;
      max_nxt   = (q_head.excess > max_r) ? q_head.excess : max_r;
    end
    var_sq = (msq_r > m2_r) ? (msq_r - m2_r) : '0;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_ACC: begin
        if (q_pop && q_head.last && count_nxt != '0) begin
          state_nxt = B_START;
        end
      end
      B_START: state_nxt = B_DIV;
      B_DIV: begin
        if (div_done) begin
          state_nxt = B_SQM;
        end
      end
      B_SQM:  state_nxt = B_ROOT;
      B_ROOT: state_nxt = B_WAIT;
      B_WAIT: begin
        if (isq_done) begin
          state_nxt = B_ACC;
        end
      end
      default: state_nxt = B_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_ACC;
      count_r     <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      min_r       <= '1;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        if (q_head.last) begin
          count_r <= '0;
          sum_r   <= '0;
          sumsq_r <= '0;
          min_r   <= '1;
          max_r   <= '0;
          if (count_nxt == '0) begin
            out_valid_r <= 1'b1;
          end
        end else begin
          count_r <= count_nxt;
          sum_r   <= sum_nxt;
          sumsq_r <= sumsq_nxt;
          min_r   <= min_nxt;
          max_r   <= max_nxt;
        end
      end
      if (state_r == B_WAIT && isq_done) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.last) begin
      snap_cnt_r   <= count_nxt;
      snap_sum_r   <= sum_nxt;
      snap_sumsq_r <= sumsq_nxt;
      snap_min_r   <= min_nxt;
      snap_max_r   <= max_nxt;
      if (count_nxt == '0) begin
        out_data_r <= '0;
      end
    end
    if (state_r == B_DIV && div_done) begin
      mean_r <= q_mean[ros_pkg::DIST_W-1:0];
      msq_r  <= q_msq[ros_pkg::SQ_W-1:0];
    end
    if (state_r == B_SQM) begin
      m2_r <= mean_r * mean_r;
    end
    if (state_r == B_WAIT && isq_done) begin
      out_data_r.mean_dist     <= mean_r;
      out_data_r.stdev_dist    <= isq_root;
      out_data_r.min_dist      <= snap_min_r;
      out_data_r.max_dist      <= snap_max_r;
      out_data_r.outside_count <= snap_cnt_r;
    end
  end

  assign div_start = (state_r == B_START);
  assign isq_start = (state_r == B_ROOT);

  ros_div u_div_mean (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ros_pkg::SUMSQ_W'(snap_sum_r)),
    .divisor  (snap_cnt_r),
    .done     (div_done),
    .quotient (q_mean)
  );

  ros_div u_div_msq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (snap_sumsq_r),
    .divisor  (snap_cnt_r),
    .done     (div_done_sq),
    .quotient (q_msq)
  );

  ros_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (isq_start),
    .x     (var_sq),
    .done  (isq_done),
    .root  (isq_root)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ROS_ASSERT_ALWAYS(a_count_limit, count_r <= ros_pkg::CNT_W'(ros_pkg::MAX_AGENTS), "count above limit")
  `ROS_ASSERT_IMPL(a_out_empty_busy, state_r != B_ACC, !out_valid_r, "result held during frame close")
  `ROS_ASSERT_IMPL(a_div_lockstep, div_done, div_done_sq, "dividers out of step")
  `ROS_ASSERT_NEXT(a_result_loaded, state_r == B_WAIT && isq_done, out_valid_r, "result not loaded")

endmodule

// ===== rtl/core/region_overshoot_statistics.sv =====
// ---------------------------------------------------------------------------
// region_overshoot_statistics
// Per-frame statistics of how far agents lie outside a sphere or a cube.
// ---------------------------------------------------------------------------
//
//   Port group   Direction   Carries
//   in_*         input       one agent position word, final_agent closes frame
//   out_*        output      one statistics word per frame
//   cfg_*        slave       centre x, centre y, radius, shape registers
//
// Each position word occupies the front until the iterative square root,
// which produces one root bit per cycle, has finished and the distance
// has entered the queue. The end of a frame runs the two dividers in the
// back side by side, one quotient bit per cycle, and then a second
// square root; meanwhile the front keeps taking words into the queue.
// Reset is synchronous and active low and clears all control state and
// the per-frame accumulators; no clearing pass is needed.
// A stalled result word holds back only the next frame end; the words
// behind it wait in the queue, and the front stalls once the queue is full.
//
// The block measures each agent's distance outside the region centred at
// (center_x, center_y, 0). Strictly positive distances are counted and
// added to a sum, a sum of squares, a running minimum and maximum. The
// word that carries final_agent makes the back emit the floor mean, the
// floor root of the clamped variance, the minimum, the maximum and the
// count, then the accumulators start over. A frame with no agent outside
// gives an all-zero word.
// ---------------------------------------------------------------------------
module region_overshoot_statistics (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  ros_pkg::ros_in_t             in_data,

  output logic                         out_valid,
  input  logic                         out_ready,
  output ros_pkg::ros_out_t            out_data,

  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [ros_pkg::APB_AW-1:0]   cfg_paddr,
  input  logic [ros_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic [ros_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  ros_pkg::ros_cfg_t cfg_r;
  ros_pkg::ros_reg_t reg_sel;
  logic              cfg_wr;

  logic              q_push;
  ros_pkg::ros_q_t   q_wdata;
  logic              q_full;
  logic              q_pop;
  logic              q_valid;
  ros_pkg::ros_q_t   q_head;

  // Registers sit on word addresses; the low two address bits are ignored.
  assign reg_sel    = ros_pkg::ros_reg_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        ros_pkg::REG_CENTER_X: cfg_r.center_x <= cfg_pwdata[ros_pkg::COORD_W-1:0];
        ros_pkg::REG_CENTER_Y: cfg_r.center_y <= cfg_pwdata[ros_pkg::COORD_W-1:0];
        ros_pkg::REG_RADIUS:   cfg_r.radius   <= cfg_pwdata[ros_pkg::RAD_W-1:0];
        ros_pkg::REG_SHAPE:    cfg_r.region_shape <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // Reads return the stored bits, zero extended.
  always_comb begin
    unique case (reg_sel)
      ros_pkg::REG_CENTER_X:
        cfg_prdata = {{(ros_pkg::APB_DW-ros_pkg::COORD_W){1'b0}}, cfg_r.center_x};
      ros_pkg::REG_CENTER_Y:
        cfg_prdata = {{(ros_pkg::APB_DW-ros_pkg::COORD_W){1'b0}}, cfg_r.center_y};
      ros_pkg::REG_RADIUS:
        cfg_prdata = {{(ros_pkg::APB_DW-ros_pkg::RAD_W){1'b0}}, cfg_r.radius};
      ros_pkg::REG_SHAPE:
        cfg_prdata = {{(ros_pkg::APB_DW-1){1'b0}}, cfg_r.region_shape};
      default:
        cfg_prdata = '0;
    endcase
  end

  // Front: geometry and per-agent distance.
  ros_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  // Queue lets the front keep working while the back closes a frame.
  ros_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // Back: accumulation, division and the result register.
  ros_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
